// ===== rtl/bpfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfr_pkg
// shared types and constants of the buffer pool frame replacement block
// ----------------------------------------------------------------------------
package bpfr_pkg;

  localparam int unsigned NumFrames = 16;
  localparam int unsigned IdxW      = $clog2(NumFrames);
  localparam int unsigned PageW     = 16;

  typedef enum logic [1:0] {
    REQ_PIN   = 2'd0,
    REQ_UNPIN = 2'd1,
    REQ_DIRTY = 2'd2,
    REQ_FORCE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_RES   = 2'd2,
    ST_NOT_PIN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2,
    POL_LFU3 = 2'd3
  } policy_e;

  localparam logic [0:0] CFG_POLICY = 1'b0;
  localparam logic [0:0] CFG_FRAMES = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [PageW-1:0] page_num;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdxW-1:0]  frame_index;
    logic             hit;
    logic             load_needed;
    logic             writeback_needed;
    logic [PageW-1:0] writeback_page;
    logic [31:0]      reads_total;
    logic [31:0]      writes_total;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/bpfr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfr_front
// request intake: two-entry queue that decouples the host from the engine
// ----------------------------------------------------------------------------
module bpfr_front import bpfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      q_valid_o,
  input  wire logic q_ready_i,
  output req_t      q_o
);

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign req_ready_o = (cnt_q != 2'd2);
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_o         = mem_q[rd_q];
  assign push        = req_valid_i && req_ready_o;
  assign pop         = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= req_i;
  end

endmodule
`default_nettype wire

// ===== rtl/bpfr_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfr_engine
// frame table, lookup, victim search over frames and state update
// ----------------------------------------------------------------------------
module bpfr_engine import bpfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i,
  input  wire logic       q_valid_i,
  output logic            q_ready_o,
  input  wire req_t       q_i,
  output logic            rsp_valid_o,
  input  wire logic       rsp_ready_i,
  output rsp_t            rsp_o
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN, S_DONE} state_e;

  state_e state_q;
  logic [1:0]  pol_q;
  logic [4:0]  fiu_q;
  logic [PageW-1:0] page_q [NumFrames];
  logic [NumFrames-1:0] valid_q, dirty_q;
  logic [7:0]  pins_q [NumFrames];
  logic [IdxW-1:0] rank_q [NumFrames];
  logic [15:0] uses_q [NumFrames];
  logic [4:0]  filled_q;
  logic [31:0] rd_cnt_q, wr_cnt_q;
  req_t        req_q;
  logic        found_q, free_q, best_ok_q;
  logic [IdxW-1:0] fidx_q, free_idx_q, best_q, scan_q;
  logic        rsp_valid_q;
  rsp_t        rsp_q;

  logic [4:0]  n;
  logic        found, free_f;
  logic [IdxW-1:0] fidx, free_idx;
  logic        better, is_lfu;
  logic [IdxW-1:0] tgt, mv_rank;
  logic        do_front, do_load;
  logic        commit;
  rsp_t        rsp_d;

  always_comb begin
    n = fiu_q;
    if (n == 5'd0) n = 5'd1;
    if (n > 5'(NumFrames)) n = 5'(NumFrames);
    found = 1'b0; fidx = '0; free_f = 1'b0; free_idx = '0;
    for (int i = NumFrames - 1; i >= 0; i--) begin
      if (5'(i) < n) begin
        if (valid_q[i] && page_q[i] == req_q.page_num) begin
          found = 1'b1; fidx = IdxW'(i);
        end
        if (!valid_q[i]) begin
          free_f = 1'b1; free_idx = IdxW'(i);
        end
      end
    end
  end

  assign is_lfu = pol_q[1];
  always_comb begin
    better = 1'b0;
    if (pins_q[scan_q] == 8'd0) begin
      if (!best_ok_q) better = 1'b1;
      else if (is_lfu)
        better = (uses_q[scan_q] < uses_q[best_q]) ||
                 (uses_q[scan_q] == uses_q[best_q] && rank_q[scan_q] > rank_q[best_q]);
      else better = rank_q[scan_q] > rank_q[best_q];
    end
  end

  assign q_ready_o   = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign commit      = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready_i);

  // commit happens in S_DONE; target frame and actions
  always_comb begin
    do_load  = (req_q.req_type == REQ_PIN) && !found_q && (free_q || best_ok_q);
    tgt      = found_q ? fidx_q : (free_q ? free_idx_q : best_q);
    do_front = do_load || ((req_q.req_type == REQ_PIN) && found_q && pol_q == POL_LRU);
    mv_rank  = rank_q[tgt];
  end

  always_comb begin
    rsp_d              = '0;
    rsp_d.reads_total  = rd_cnt_q;
    rsp_d.writes_total = wr_cnt_q;
    if (req_q.req_type == REQ_PIN) begin
      if (found_q) begin
        rsp_d.hit         = 1'b1;
        rsp_d.frame_index = fidx_q;
      end else if (do_load) begin
        if (valid_q[tgt] && dirty_q[tgt]) begin
          rsp_d.writeback_needed = 1'b1;
          rsp_d.writeback_page   = page_q[tgt];
          rsp_d.writes_total     = wr_cnt_q + 32'd1;
        end
        rsp_d.load_needed = 1'b1;
        rsp_d.reads_total = rd_cnt_q + 32'd1;
        rsp_d.frame_index = tgt;
      end else begin
        rsp_d.status = ST_NO_SPACE;
      end
    end else if (!found_q) begin
      rsp_d.status = ST_NOT_RES;
    end else if (req_q.req_type == REQ_UNPIN) begin
      if (pins_q[fidx_q] == 8'd0) rsp_d.status = ST_NOT_PIN;
      else rsp_d.frame_index = fidx_q;
    end else if (req_q.req_type == REQ_DIRTY) begin
      rsp_d.frame_index = fidx_q;
    end else begin
      rsp_d.writeback_needed = 1'b1;
      rsp_d.writeback_page   = page_q[fidx_q];
      rsp_d.writes_total     = wr_cnt_q + 32'd1;
      rsp_d.frame_index      = fidx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && do_load) page_q[tgt] <= req_q.page_num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pol_q       <= POL_FIFO;
      fiu_q       <= 5'd16;
      valid_q     <= '0;
      dirty_q     <= '0;
      filled_q    <= '0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      req_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      best_ok_q   <= 1'b0;
      fidx_q      <= '0;
      free_idx_q  <= '0;
      best_q      <= '0;
      scan_q      <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        pins_q[i] <= '0;
        uses_q[i] <= '0;
        rank_q[i] <= IdxW'(i);
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_POLICY) pol_q <= cfg_data_i[1:0];
        else fiu_q <= cfg_data_i;
      end
      if (commit) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            req_q   <= q_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          found_q    <= found;
          fidx_q     <= fidx;
          free_q     <= free_f;
          free_idx_q <= free_idx;
          best_ok_q  <= 1'b0;
          best_q     <= '0;
          scan_q     <= '0;
          if (req_q.req_type == REQ_PIN && !found && !free_f) state_q <= S_SCAN;
          else state_q <= S_DONE;
        end
        S_SCAN: begin
          if (better) begin
            best_q    <= scan_q;
            best_ok_q <= 1'b1;
          end
          if (5'(scan_q) + 5'd1 >= n) state_q <= S_DONE;
          else scan_q <= scan_q + IdxW'(1);
        end
        S_DONE: begin
          if (commit) begin
            rsp_q    <= rsp_d;
            rd_cnt_q <= rsp_d.reads_total;
            wr_cnt_q <= rsp_d.writes_total;
            if (req_q.req_type == REQ_PIN) begin
              if (found_q) begin
                if (pins_q[fidx_q] != 8'hff) pins_q[fidx_q] <= pins_q[fidx_q] + 8'd1;
                if (uses_q[fidx_q] != 16'hffff) uses_q[fidx_q] <= uses_q[fidx_q] + 16'd1;
              end else if (do_load) begin
                if (free_q && filled_q < 5'(NumFrames)) filled_q <= filled_q + 5'd1;
                valid_q[tgt] <= 1'b1;
                dirty_q[tgt] <= 1'b0;
                pins_q[tgt]  <= 8'd1;
                uses_q[tgt]  <= 16'd1;
              end
            end else if (found_q) begin
              if (req_q.req_type == REQ_UNPIN) begin
                if (pins_q[fidx_q] != 8'd0) pins_q[fidx_q] <= pins_q[fidx_q] - 8'd1;
              end else begin
                dirty_q[fidx_q] <= (req_q.req_type == REQ_DIRTY);
              end
            end
            if (do_front) begin
              for (int i = 0; i < NumFrames; i++) begin
                if (rank_q[i] < mv_rank) rank_q[i] <= rank_q[i] + IdxW'(1);
              end
              rank_q[tgt] <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/buffer_pool_frame_replacement.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_pool_frame_replacement
// page replacement controller for a buffer pool (FIFO, LRU, LFU)
// ----------------------------------------------------------------------------
// channel  dir  handshake                     payload
// req      in   req_valid_i / req_ready_o     req_i (req_t)
// rsp      out  rsp_valid_o / rsp_ready_i     rsp_o (rsp_t)
// cfg      in   cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// the engine takes a beat, looks it up and commits it (S_IDLE, S_LOOK,
// S_DONE); a pin miss with no free frame adds a victim scan over each frame
// of the configured pool (S_SCAN). a two-beat queue in front takes beats while
// the engine works; the result register holds until rsp_ready_i.
// reset clears all control and frame status at once.
// ----------------------------------------------------------------------------
module buffer_pool_frame_replacement import bpfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire req_t       req_i,
  output logic            rsp_valid_o,
  input  wire logic       rsp_ready_i,
  output rsp_t            rsp_o
);

  logic q_valid, q_ready;
  req_t q_req;

  assign cfg_ready_o = 1'b1;

  bpfr_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_o(q_req)
  );

  bpfr_engine u_engine (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_i(q_req),
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  a_load_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.load_needed |-> rsp_o.status == ST_OK && !rsp_o.hit)
    else $error("load with bad status");

  a_hit_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.hit |-> !rsp_o.load_needed && !rsp_o.writeback_needed)
    else $error("hit with disk traffic");

  a_wb_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.writeback_needed |-> rsp_o.writeback_page == '0)
    else $error("stray writeback page");

endmodule
`default_nettype wire

// ===== dv/buffer_pool_frame_replacement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_frame_replacement_checker
// watches the request, response and config channels, keeps a model of the
// frame table, predicts each response beat and compares it field by field
// ----------------------------------------------------------------------------
module buffer_pool_frame_replacement_checker import bpfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [0:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  input  logic       req_valid_i,
  input  logic       req_ready_i,
  input  req_t       req_i,
  input  logic       rsp_valid_i,
  input  logic       rsp_ready_i,
  input  rsp_t       rsp_i,
  output int         fail_count_o,
  output int         pending_o
);

  logic [1:0]  policy;
  logic [4:0]  pool_cfg;
  logic [15:0] pg    [NumFrames];
  logic        vld   [NumFrames];
  logic        dty   [NumFrames];
  logic [7:0]  pins  [NumFrames];
  logic [3:0]  rank  [NumFrames];
  logic [15:0] uses  [NumFrames];
  logic [31:0] reads, writes;
  rsp_t        rsp_queue[$];

  int fails;
  assign fail_count_o = fails;
  assign pending_o    = rsp_queue.size();

  function automatic int pool_size();
    int n;
    n = int'(pool_cfg);
    if (n == 0) n = 1;
    if (n > NumFrames) n = NumFrames;
    return n;
  endfunction

  function automatic void move_front(int f);
    logic [3:0] r;
    r = rank[f];
    for (int i = 0; i < NumFrames; i++) if (rank[i] < r) rank[i]++;
    rank[f] = 4'd0;
  endfunction

  function automatic int choose_victim();
    int best;
    best = -1;
    for (int i = 0; i < pool_size(); i++) begin
      if (pins[i] != 0) continue;
      if (best < 0) best = i;
      else if (policy >= POL_LFU) begin
        if (uses[i] < uses[best] || (uses[i] == uses[best] && rank[i] > rank[best]))
          best = i;
      end else if (rank[i] > rank[best]) best = i;
    end
    return best;
  endfunction

  function automatic rsp_t serve_request(req_t q);
    rsp_t r;
    int f, v;
    r = '0;
    f = -1;
    for (int i = 0; i < pool_size(); i++)
      if (f < 0 && vld[i] && pg[i] == q.page_num) f = i;
    if (q.req_type == REQ_PIN) begin
      if (f >= 0) begin
        r.hit = 1'b1;
        r.frame_index = 4'(f);
        if (pins[f] != 8'hff) pins[f]++;
        if (uses[f] != 16'hffff) uses[f]++;
        if (policy == POL_LRU) move_front(f);
      end else begin
        v = -1;
        for (int i = 0; i < pool_size(); i++) if (v < 0 && !vld[i]) v = i;
        if (v < 0) v = choose_victim();
        if (v < 0) r.status = ST_NO_SPACE;
        else begin
          if (vld[v] && dty[v]) begin
            r.writeback_needed = 1'b1;
            r.writeback_page = pg[v];
            writes++;
          end
          pg[v] = q.page_num;
          vld[v] = 1'b1;
          dty[v] = 1'b0;
          pins[v] = 8'd1;
          uses[v] = 16'd1;
          move_front(v);
          r.load_needed = 1'b1;
          reads++;
          r.frame_index = 4'(v);
        end
      end
    end else if (f < 0) r.status = ST_NOT_RES;
    else if (q.req_type == REQ_UNPIN) begin
      if (pins[f] == 0) r.status = ST_NOT_PIN;
      else begin
        pins[f]--;
        r.frame_index = 4'(f);
      end
    end else if (q.req_type == REQ_DIRTY) begin
      dty[f] = 1'b1;
      r.frame_index = 4'(f);
    end else begin
      r.writeback_needed = 1'b1;
      r.writeback_page = pg[f];
      dty[f] = 1'b0;
      writes++;
      r.frame_index = 4'(f);
    end
    r.reads_total = reads;
    r.writes_total = writes;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      policy = POL_FIFO;
      pool_cfg = 5'd16;
      for (int i = 0; i < NumFrames; i++) begin
        pg[i] = '0; vld[i] = 1'b0; dty[i] = 1'b0; pins[i] = '0; uses[i] = '0;
        rank[i] = 4'(i);
      end
      reads = '0;
      writes = '0;
      fails = 0;
      rsp_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_POLICY) policy = cfg_data_i[1:0];
        else pool_cfg = cfg_data_i;
      end
      if (req_valid_i && req_ready_i) rsp_queue.push_back(serve_request(req_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (rsp_queue.size() == 0) begin
          $error("response beat with no request outstanding");
          fails++;
        end else begin
          e = rsp_queue.pop_front();
          check_field("status", 32'(e.status), 32'(rsp_i.status));
          check_field("frame_index", 32'(e.frame_index), 32'(rsp_i.frame_index));
          check_field("hit", 32'(e.hit), 32'(rsp_i.hit));
          check_field("load_needed", 32'(e.load_needed), 32'(rsp_i.load_needed));
          check_field("writeback_needed", 32'(e.writeback_needed),
                      32'(rsp_i.writeback_needed));
          check_field("writeback_page", 32'(e.writeback_page), 32'(rsp_i.writeback_page));
          check_field("reads_total", e.reads_total, rsp_i.reads_total);
          check_field("writes_total", e.writes_total, rsp_i.writes_total);
        end
      end
    end
  end

endmodule

// ===== dv/buffer_pool_frame_replacement_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_frame_replacement_tb
// drives directed and random pin, unpin, dirty and force traffic over
// several policies and pool sizes, with random stalls on both channels
// ----------------------------------------------------------------------------
module buffer_pool_frame_replacement_tb;
  import bpfr_pkg::*;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       cfg_valid_i = 0;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [4:0] cfg_data_i = '0;
  logic       req_valid_i = 0;
  logic       req_ready_o;
  req_t       req_i = '0;
  logic       rsp_valid_o;
  logic       rsp_ready_i = 0;
  rsp_t       rsp_o;
  int         fail_count, pending;
  int         cycles = 0;
  bit         hold_rsp = 0;
  logic [15:0] hot_pages[8];

  buffer_pool_frame_replacement dut (.*);

  buffer_pool_frame_replacement_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .req_valid_i, .req_ready_i(req_ready_o), .req_i, .rsp_valid_i(rsp_valid_o),
    .rsp_ready_i, .rsp_i(rsp_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("buffer_pool_frame_replacement: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, or held off entirely
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0 || hold_rsp) begin
        rsp_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
        while (hold_rsp) @(posedge clk_i);
      end
      rsp_ready_i <= 1;
      @(posedge clk_i);
      while (!rsp_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_req(req_e kind, logic [15:0] page, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      req_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1;
    req_i <= '{req_type: kind, page_num: page};
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    req_valid_i <= 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [4:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_page();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : hot_pages[$urandom_range(0, 7)];
  endfunction

  initial begin
    logic [4:0] sizes[6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9};
    int r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: fill, pin to saturation of space, extremes, error paths
    write_cfg(CFG_FRAMES, 5'd2);
    send_req(REQ_UNPIN, 16'h0000);
    send_req(REQ_DIRTY, 16'hffff);
    send_req(REQ_FORCE, 16'h1234);
    send_req(REQ_PIN, 16'h0000);
    send_req(REQ_PIN, 16'hffff);
    send_req(REQ_PIN, 16'h5555);
    send_req(REQ_PIN, 16'hffff);
    send_req(REQ_DIRTY, 16'hffff);
    send_req(REQ_UNPIN, 16'hffff);
    send_req(REQ_UNPIN, 16'hffff);
    send_req(REQ_UNPIN, 16'hffff);
    send_req(REQ_PIN, 16'haaaa);
    send_req(REQ_FORCE, 16'h0000);
    send_req(REQ_UNPIN, 16'h0000);
    send_req(REQ_DIRTY, 16'haaaa);
    send_req(REQ_UNPIN, 16'haaaa);
    send_req(REQ_PIN, 16'h7777);
    send_req(REQ_UNPIN, 16'h7777);
    send_req(REQ_PIN, 16'h8000);
    drain();
    for (int i = 0; i < 300; i++) send_req(REQ_PIN, 16'h0000, 1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(CFG_POLICY, 5'(ph % 4));
      write_cfg(CFG_FRAMES, sizes[ph % 6]);
      for (int k = 0; k < 8; k++) hot_pages[k] = (ph % 2) ? 16'($urandom) : 16'(k + ph * 8);
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 9);
        if (r < 5) send_req(REQ_PIN, pick_page());
        else if (r < 8) send_req(REQ_UNPIN, pick_page());
        else if (r < 9) send_req(REQ_DIRTY, pick_page());
        else send_req(REQ_FORCE, pick_page());
      end
      if (ph == 3) begin
        hold_rsp = 1;
        fork
          begin
            repeat (200) @(posedge clk_i);
            hold_rsp = 0;
          end
          for (int i = 0; i < 12; i++) send_req(REQ_UNPIN, pick_page(), 1);
        join
      end
      drain();
    end

    write_cfg(CFG_POLICY, 5'(POL_LRU));
    write_cfg(CFG_FRAMES, 5'd16);
    drain();
    if (fail_count == 0) begin
      $display("buffer_pool_frame_replacement: match");
    end else begin
      $display("buffer_pool_frame_replacement: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bpfr_pkg.sv
rtl/bpfr_front.sv
rtl/bpfr_engine.sv
rtl/buffer_pool_frame_replacement.sv
dv/buffer_pool_frame_replacement_checker.sv
dv/buffer_pool_frame_replacement_tb.sv
